// ===== hw/rtl/sldf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sldf_pkg: shared types and constants for the sync/length frame deframer
// Result layout, result kinds, register indexes and header sizing.
// ----------------------------------------------------------------------------
package sldf_pkg;

  localparam int MAX_PAYLOAD_DEFAULT = 256;
  localparam int HEADER_BYTES        = 6;
  localparam int LEN_W               = 16;
  localparam int CFG_IDX_W           = 2;
  localparam int CFG_DATA_W          = 8;

  localparam logic [7:0] SYNC_FIRST_RESET  = 8'h55;
  localparam logic [7:0] SYNC_SECOND_RESET = 8'hAA;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_LONG    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       version;
    logic [15:0]      sequence_res;
    logic [7:0]       command;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       payload_byte;
    logic [7:0]       payload_index;
    logic             last;
  } res_t;

endpackage

// ===== hw/rtl/sldf_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sldf_parser: frame state machine
// Updates the frame state on each accepted byte and forms the result, if any.
// ----------------------------------------------------------------------------
module sldf_parser #(
  parameter int MAX_PAYLOAD = sldf_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sldf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sldf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_fire,
  input  logic [7:0]                     rx_byte,
  output logic                           res_emit,
  output sldf_pkg::res_t                 res
);

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [2:0] {
    HUNT1, HUNT2, HEADER, PAYLOAD, CHECK
  } phase_t;

  phase_t                      phase, phase_next;
  logic [2:0]                  header_count, header_count_next;
  logic [7:0]                  frame_version, frame_version_next;
  logic [15:0]                 frame_sequence, frame_sequence_next;
  logic [7:0]                  frame_command, frame_command_next;
  logic [sldf_pkg::LEN_W-1:0]  frame_length, frame_length_next;
  logic [7:0]                  running_sum, running_sum_next;
  logic [CNT_W-1:0]            payload_count, payload_count_next;
  logic [7:0]                  sync_first, sync_second;

  logic [CNT_W-1:0]            count_inc;
  logic [15:0]                 count_wide;

  assign count_inc  = payload_count + CNT_W'(1);
  assign count_wide = 16'(payload_count);

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    frame_version_next  = frame_version;
    frame_sequence_next = frame_sequence;
    frame_command_next  = frame_command;
    frame_length_next   = frame_length;
    running_sum_next    = running_sum;
    payload_count_next  = payload_count;
    res_emit            = 1'b0;
    res.kind            = sldf_pkg::KIND_PAYLOAD;
    res.payload_byte    = 8'd0;
    res.payload_index   = 8'd0;
    res.last            = 1'b0;

    if (in_fire) begin
      case (phase)
        HUNT2: begin
          if (rx_byte != sync_second) begin
            phase_next = HUNT1;
          end else begin
            running_sum_next  = running_sum + rx_byte;
            header_count_next = 3'd0;
            phase_next        = HEADER;
          end
        end
        HEADER: begin
          running_sum_next = running_sum + rx_byte;
          case (header_count)
            3'd0:    frame_version_next  = rx_byte;
            3'd1:    frame_sequence_next = {rx_byte, 8'd0};
            3'd2:    frame_sequence_next = {frame_sequence[15:8], rx_byte};
            3'd3:    frame_command_next  = rx_byte;
            3'd4:    frame_length_next   = {rx_byte, 8'd0};
            default: frame_length_next   = {frame_length[15:8], rx_byte};
          endcase
          if (header_count < 3'(sldf_pkg::HEADER_BYTES - 1)) begin
            header_count_next = header_count + 3'd1;
          end else begin
            header_count_next  = 3'd0;
            payload_count_next = '0;
            if (frame_length_next > 16'(MAX_PAYLOAD)) begin
              // oversize frame: report and go back to hunting
              phase_next = HUNT1;
              res_emit   = 1'b1;
              res.kind   = sldf_pkg::KIND_LONG;
              res.last   = 1'b1;
            end else if (frame_length_next == '0) begin
              phase_next = CHECK;
            end else begin
              phase_next = PAYLOAD;
            end
          end
        end
        PAYLOAD: begin
          running_sum_next   = running_sum + rx_byte;
          res_emit           = 1'b1;
          res.payload_byte   = rx_byte;
          res.payload_index  = count_wide[7:0];
          payload_count_next = count_inc;
          if (16'(count_inc) >= frame_length) begin
            phase_next = CHECK;
          end
        end
        CHECK: begin
          phase_next = HUNT1;
          res_emit   = 1'b1;
          res.kind   = (rx_byte == running_sum) ? sldf_pkg::KIND_GOOD : sldf_pkg::KIND_BAD;
          res.last   = 1'b1;
        end
        default: begin
          phase_next = HUNT1;
          if (rx_byte == sync_first) begin
            running_sum_next = rx_byte;
            phase_next       = HUNT2;
          end
        end
      endcase
    end

    // header fields reflect this byte's update (matters for the oversize report)
    res.version        = frame_version_next;
    res.sequence_res   = frame_sequence_next;
    res.command        = frame_command_next;
    res.payload_length = frame_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= HUNT1;
      header_count   <= 3'd0;
      frame_version  <= 8'd0;
      frame_sequence <= 16'd0;
      frame_command  <= 8'd0;
      frame_length   <= '0;
      running_sum    <= 8'd0;
      payload_count  <= '0;
      sync_first     <= sldf_pkg::SYNC_FIRST_RESET;
      sync_second    <= sldf_pkg::SYNC_SECOND_RESET;
    end else begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      frame_version  <= frame_version_next;
      frame_sequence <= frame_sequence_next;
      frame_command  <= frame_command_next;
      frame_length   <= frame_length_next;
      running_sum    <= running_sum_next;
      payload_count  <= payload_count_next;
      if (cfg_we && cfg_index == sldf_pkg::CFG_SYNC_FIRST) begin
        sync_first <= cfg_data;
      end
      if (cfg_we && cfg_index == sldf_pkg::CFG_SYNC_SECOND) begin
        sync_second <= cfg_data;
      end
    end
  end

endmodule

// ===== hw/rtl/sldf_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sldf_out_fifo: two-entry result buffer
// Decouples the parser from a stalling receiver; full when both slots hold.
// ----------------------------------------------------------------------------
module sldf_out_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sldf_pkg::res_t push_data,
  output logic           full,
  output logic           pop_valid,
  input  logic           pop_ready,
  output sldf_pkg::res_t pop_data
);

  sldf_pkg::res_t slot [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;
  logic           pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/sync_length_frame_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_top: serial byte frame deframer
// Sync hunt, header capture, payload streaming and sum-8 frame check.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel (rx_valid/rx_ready/rx_byte) takes one received byte per
//   transfer. res channel (res_valid/res_ready + fields) returns zero or one
//   result per byte: each payload byte with its index, then an end result
//   (good, checksum bad, or length too long) with last set.
//   Throughput: one byte per cycle while the output buffer is not full. The frame
//   state is updated in the cycle the byte transfers; its result lands in a
//   two-entry output buffer and is visible on res the next cycle if the buffer was empty.
//   rx_ready drops only when both buffer slots hold results, so the block
//   keeps taking bytes while one result waits on a stalled receiver; a long
//   stall backs up into the rx channel after two results.
//   Reset (rst, synchronous) empties the buffer, restarts the sync hunt and
//   restores sync bytes 0x55 / 0xAA. Sync bytes are written through
//   cfg_we/cfg_index/cfg_data; the user must write them only while the block
//   is idle, which the block does not enforce. Unknown indexes are ignored.
// ----------------------------------------------------------------------------
module sync_length_frame_deframer_top #(
  parameter int MAX_PAYLOAD = sldf_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sldf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sldf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            rx_valid,
  output logic                            rx_ready,
  input  logic [7:0]                      rx_byte,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [1:0]                      kind,
  output logic [7:0]                      version,
  output logic [15:0]                     sequence_res,
  output logic [7:0]                      command,
  output logic [sldf_pkg::LEN_W-1:0]      payload_length,
  output logic [7:0]                      payload_byte,
  output logic [7:0]                      payload_index,
  output logic                            last
);

  logic           in_fire;
  logic           res_emit;
  logic           buf_full;
  sldf_pkg::res_t res_new;
  sldf_pkg::res_t res_out;

  assign rx_ready = !buf_full;
  assign in_fire  = rx_valid && rx_ready;

  sldf_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_fire  (in_fire),
    .rx_byte  (rx_byte),
    .res_emit (res_emit),
    .res      (res_new)
  );

  // results queue here so a stalled receiver does not block the next byte
  sldf_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (res_emit),
    .push_data(res_new),
    .full     (buf_full),
    .pop_valid(res_valid),
    .pop_ready(res_ready),
    .pop_data (res_out)
  );

  assign kind           = res_out.kind;
  assign version        = res_out.version;
  assign sequence_res   = res_out.sequence_res;
  assign command        = res_out.command;
  assign payload_length = res_out.payload_length;
  assign payload_byte   = res_out.payload_byte;
  assign payload_index  = res_out.payload_index;
  assign last           = res_out.last;

  // end results carry last, payload results never do
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (last == (kind != sldf_pkg::KIND_PAYLOAD)))
    else $error("last flag disagrees with result kind");

  // oversize report only for a declared length above the limit
  a_long_len: assert property (@(posedge clk) disable iff (rst)
    (res_valid && kind == sldf_pkg::KIND_LONG) |-> (payload_length > 16'(MAX_PAYLOAD)))
    else $error("length-too-long result with a legal length");

  // a payload byte never comes from an empty or oversize frame
  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    (res_valid && kind == sldf_pkg::KIND_PAYLOAD) |->
      (payload_length != '0 && payload_length <= 16'(MAX_PAYLOAD)))
    else $error("payload byte with zero or oversize length");

  // backpressure only when results are actually waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> res_valid)
    else $error("rx stalled with no result pending");

endmodule

// ===== test/sync_length_frame_deframer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_top_tb: self-checking bench for the frame deframer
// Drives received bytes over rx and tracks the frame state in a local copy.
// Every result on res is checked field by field against the oldest pending
// expectation. Directed frames come first, then random traffic under three
// stall mixes.
// ----------------------------------------------------------------------------
module sync_length_frame_deframer_top_tb;

  localparam int MAX_PAY   = sldf_pkg::MAX_PAYLOAD_DEFAULT;
  localparam int LIMIT     = 400000;
  localparam int SETTLE    = 4;
  // indexes past the two sync registers; the block must ignore these
  localparam logic [sldf_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [sldf_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, IN_HEADER, IN_PAYLOAD, IN_CHECK
  } deframe_phase_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_we    = 1'b0;
  logic [sldf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sldf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                            rx_valid  = 1'b0;
  logic                            rx_ready;
  logic [7:0]                      rx_byte   = '0;
  logic                            res_valid;
  logic                            res_ready = 1'b0;
  logic [1:0]                      kind;
  logic [7:0]                      version;
  logic [15:0]                     sequence_res;
  logic [7:0]                      command;
  logic [sldf_pkg::LEN_W-1:0]      payload_length;
  logic [7:0]                      payload_byte;
  logic [7:0]                      payload_index;
  logic                            last;

  sync_length_frame_deframer_top #(.MAX_PAYLOAD(MAX_PAY)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .rx_valid(rx_valid), .rx_ready(rx_ready), .rx_byte(rx_byte),
    .res_valid(res_valid), .res_ready(res_ready),
    .kind(kind), .version(version), .sequence_res(sequence_res),
    .command(command), .payload_length(payload_length),
    .payload_byte(payload_byte), .payload_index(payload_index), .last(last)
  );

  initial forever #1 clk = ~clk;

  // stall mix, in percent of cycles
  int send_idle = 7;
  int recv_idle = 68;

  int cycle_count = 0;
  int mismatches  = 0;
  int bytes_sent  = 0;

  // local copy of the deframer state and its sync registers
  logic [7:0]     sync_a = sldf_pkg::SYNC_FIRST_RESET;
  logic [7:0]     sync_b = sldf_pkg::SYNC_SECOND_RESET;
  deframe_phase_t ph     = HUNT_FIRST;
  logic [2:0]     hdr_cnt = '0;
  logic [7:0]     f_ver   = '0;
  logic [15:0]    f_seq   = '0;
  logic [7:0]     f_cmd   = '0;
  logic [15:0]    f_len   = '0;
  logic [7:0]     sum8    = '0;
  logic [15:0]    pay_cnt = '0;

  sldf_pkg::res_t pending_results[$];
  sldf_pkg::res_t want;

  function automatic void expect_result(sldf_pkg::kind_t k, logic [7:0] pb,
                                        logic [7:0] pi, logic lst);
    sldf_pkg::res_t r;
    r.kind           = k;
    r.version        = f_ver;
    r.sequence_res   = f_seq;
    r.command        = f_cmd;
    r.payload_length = f_len;
    r.payload_byte   = pb;
    r.payload_index  = pi;
    r.last           = lst;
    pending_results.push_back(r);
  endfunction

  // advance the local frame state by one accepted byte
  function automatic void deframe_byte(input logic [7:0] b);
    case (ph)
      HUNT_SECOND: begin
        // a wrong second sync byte is dropped outright, not retried as first
        if (b != sync_b) begin
          ph = HUNT_FIRST;
        end else begin
          sum8    = sum8 + b;
          hdr_cnt = '0;
          ph      = IN_HEADER;
        end
      end
      IN_HEADER: begin
        sum8 = sum8 + b;
        case (hdr_cnt)
          3'd0:    f_ver = b;
          3'd1:    f_seq = {b, 8'h00};
          3'd2:    f_seq = f_seq | {8'h00, b};
          3'd3:    f_cmd = b;
          3'd4:    f_len = {b, 8'h00};
          default: f_len = f_len | {8'h00, b};
        endcase
        hdr_cnt = hdr_cnt + 3'd1;
        if (int'(hdr_cnt) == sldf_pkg::HEADER_BYTES) begin
          hdr_cnt = '0;
          pay_cnt = '0;
          if (int'(f_len) > MAX_PAY) begin
            // oversize frame is flagged on the low length byte and dropped
            ph = HUNT_FIRST;
            expect_result(sldf_pkg::KIND_LONG, 8'h00, 8'h00, 1'b1);
          end else begin
            ph = (f_len == 16'd0) ? IN_CHECK : IN_PAYLOAD;
          end
        end
      end
      IN_PAYLOAD: begin
        sum8 = sum8 + b;
        expect_result(sldf_pkg::KIND_PAYLOAD, b, pay_cnt[7:0], 1'b0);
        pay_cnt = pay_cnt + 16'd1;
        if (pay_cnt >= f_len) ph = IN_CHECK;
      end
      IN_CHECK: begin
        ph = HUNT_FIRST;
        expect_result((b == sum8) ? sldf_pkg::KIND_GOOD : sldf_pkg::KIND_BAD,
                      8'h00, 8'h00, 1'b1);
      end
      default: begin
        ph = HUNT_FIRST;
        if (b == sync_a) begin
          sum8 = b;
          ph   = HUNT_SECOND;
        end
      end
    endcase
  endfunction

  function automatic void report(input string what, input logic [15:0] exp_v,
                                 input logic [15:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0h, got %0h", what, exp_v, act_v);
  endfunction

  // one byte transfer on rx; the local state advances at the accepting edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!rx_ready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // stop sending, let every pending result come out, then settle
  task automatic drain();
    rx_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sldf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == sldf_pkg::CFG_SYNC_FIRST)       sync_a = val;
    else if (idx == sldf_pkg::CFG_SYNC_SECOND) sync_b = val;
  endtask

  // push bytes until the deframer is back to hunting the first sync byte
  task automatic resync();
    logic [7:0] b;
    while (ph != HUNT_FIRST) begin
      b = 8'($urandom);
      if (ph == HUNT_SECOND && b == sync_b) b = b ^ 8'h01;
      send_byte(b);
    end
  endtask

  task automatic send_frame(input logic [7:0] ver, input logic [15:0] seq,
                            input logic [7:0] cmd, input logic [15:0] len,
                            input bit corrupt);
    logic [7:0] chk;
    resync();
    send_byte(sync_a);
    send_byte(sync_b);
    send_byte(ver);
    send_byte(seq[15:8]);
    send_byte(seq[7:0]);
    send_byte(cmd);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    if (int'(len) > MAX_PAY) return;
    for (int i = 0; i < int'(len); i++) send_byte(8'($urandom));
    chk = sum8;
    if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
    send_byte(chk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_good_frames();
    send_frame(8'h00, 16'h0000, 8'h00, 16'd1, 1'b0);
    send_frame(8'hFF, 16'hFFFF, 8'hFF, 16'd3, 1'b0);
    send_frame(8'hA5, 16'h5AA5, 8'h3C, 16'd2, 1'b0);
  endtask

  task automatic test_zero_length();
    // checksum byte follows the header directly
    send_frame(8'h01, 16'h1234, 8'h07, 16'd0, 1'b0);
    send_frame(8'h02, 16'h8001, 8'h80, 16'd0, 1'b1);
  endtask

  task automatic test_bad_checksum();
    send_frame(8'h10, 16'h00FF, 8'h20, 16'd2, 1'b1);
  endtask

  task automatic test_sync_mismatch();
    resync();
    // wrong second byte: dropped, hunt restarts
    send_byte(sync_a);
    send_byte(sync_a ^ 8'h01);
    // a repeated first sync byte in second position is dropped too
    send_byte(sync_a);
    send_byte(sync_a);
    send_byte(sync_b);
    // noise with no sync byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'h33, 16'h4321, 8'h11, 16'd1, 1'b0);
  endtask

  task automatic test_oversize_length();
    send_frame(8'h44, 16'hBEEF, 8'h55, 16'(MAX_PAY + 1), 1'b0);
    send_frame(8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b0);
    send_frame(8'h00, 16'h0000, 8'h00, 16'h0100 | 16'h8000, 1'b0);
  endtask

  task automatic test_max_payload();
    // longest accepted payload walks the index through 0..255
    send_frame(8'h5A, 16'hC001, 8'h99, 16'(MAX_PAY), 1'b0);
  endtask

  task automatic test_sync_registers();
    write_reg(sldf_pkg::CFG_SYNC_FIRST, 8'h00);
    write_reg(sldf_pkg::CFG_SYNC_SECOND, 8'hFF);
    send_frame(8'h01, 16'h0102, 8'h03, 16'd2, 1'b0);
    write_reg(sldf_pkg::CFG_SYNC_FIRST, 8'hFF);
    write_reg(sldf_pkg::CFG_SYNC_SECOND, 8'h00);
    send_frame(8'h04, 16'h0506, 8'h07, 16'd1, 1'b1);
    // spare indexes must leave both sync bytes alone
    write_reg(CFG_SPARE_A, 8'h12);
    write_reg(CFG_SPARE_B, 8'h34);
    send_frame(8'h08, 16'h090A, 8'h0B, 16'd1, 1'b0);
    // identical sync bytes
    write_reg(sldf_pkg::CFG_SYNC_FIRST, 8'h7E);
    write_reg(sldf_pkg::CFG_SYNC_SECOND, 8'h7E);
    send_frame(8'h0C, 16'h0D0E, 8'h0F, 16'd0, 1'b0);
    write_reg(sldf_pkg::CFG_SYNC_FIRST, sldf_pkg::SYNC_FIRST_RESET);
    write_reg(sldf_pkg::CFG_SYNC_SECOND, sldf_pkg::SYNC_SECOND_RESET);
  endtask

  task automatic test_random_traffic(input int s_idle, input int r_idle,
                                     input bit random_sync, input int budget);
    int         stop_at;
    int         pick;
    int         n;
    logic [15:0] len;
    drain();
    send_idle = s_idle;
    recv_idle = r_idle;
    if (random_sync) begin
      write_reg(sldf_pkg::CFG_SYNC_FIRST, 8'($urandom));
      write_reg(sldf_pkg::CFG_SYNC_SECOND, 8'($urandom));
    end else begin
      write_reg(sldf_pkg::CFG_SYNC_FIRST, sldf_pkg::SYNC_FIRST_RESET);
      write_reg(sldf_pkg::CFG_SYNC_SECOND, sldf_pkg::SYNC_SECOND_RESET);
    end
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        n = $urandom_range(99);
        if (n < 72)      len = 16'($urandom_range(0, 8));
        else if (n < 92) len = 16'($urandom_range(9, 40));
        else if (n < 93) len = 16'($urandom_range(200, MAX_PAY));
        else             len = 16'($urandom_range(MAX_PAY + 1, 65535));
        send_frame(8'($urandom), 16'($urandom), 8'($urandom), len,
                   $urandom_range(99) < 15);
      end else if (pick < 85) begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(8'($urandom));
      end else if (pick < 92) begin
        resync();
        send_byte(sync_a);
        send_byte(8'($urandom));
      end else begin
        // header cut short; the next frame resyncs behind it
        resync();
        send_byte(sync_a);
        send_byte(sync_b);
        n = $urandom_range(1, 5);
        repeat (n) send_byte(8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_good_frames();
    test_zero_length();
    test_bad_checksum();
    test_sync_mismatch();
    test_oversize_length();
    test_max_payload();
    test_sync_registers();
    test_random_traffic(7, 68, 1'b1, 200);
    test_random_traffic(68, 7, 1'b1, 200);
    test_random_traffic(0, 0, 1'b0, 200);
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("PASS sync_length_frame_deframer_top");
    else
      $display("FAIL sync_length_frame_deframer_top");
    $finish;
  end

  // receiver backpressure
  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_idle);
  end

  // result checker: each res transfer against the oldest pending expectation
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result kind", 16'h0, 16'(kind));
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind)
          report("kind", 16'(want.kind), 16'(kind));
        if (version !== want.version)
          report("version", 16'(want.version), 16'(version));
        if (sequence_res !== want.sequence_res)
          report("sequence_res", want.sequence_res, sequence_res);
        if (command !== want.command)
          report("command", 16'(want.command), 16'(command));
        if (payload_length !== want.payload_length)
          report("payload_length", want.payload_length, payload_length);
        if (payload_byte !== want.payload_byte)
          report("payload_byte", 16'(want.payload_byte), 16'(payload_byte));
        if (payload_index !== want.payload_index)
          report("payload_index", 16'(want.payload_index), 16'(payload_index));
        if (last !== want.last)
          report("last", 16'(want.last), 16'(last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("FAIL sync_length_frame_deframer_top");
      $finish;
    end
  end

endmodule
